/* src/lmn_pkg.sv */
// ----------------------------------------------------------------------------
// lmn_pkg
// Shared types, widths, constants and the depth decode for the link M/N
// ratio calculator.
// ----------------------------------------------------------------------------
package lmn_pkg;

   localparam int PCLK_W    = 20;
   localparam int DEPTH_W   = 3;
   localparam int LANE_W    = 4;
   localparam int FREQ_W    = 12;
   localparam int MN_W      = 24;
   localparam int BPP_W     = 6;
   localparam int BW_W      = 19;
   localparam int NUM_W     = PCLK_W + BPP_W;
   localparam int SPEED_W   = LANE_W + BW_W + 3;
   localparam int N_W       = 24;
   localparam int N_LOG_MAX = 23;
   localparam int DVD_W     = NUM_W + N_LOG_MAX;
   localparam int REM_W     = SPEED_W;

   localparam int MAX_LANES = 4;
   localparam int BW_SCALE  = 1000 / 10;

   localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(2700);
   localparam logic [N_W-1:0]    N_CAP      = N_W'(24'h800000);
   localparam logic [MN_W-1:0]   MN_MAX     = MN_W'(24'hFFFFFF);

   localparam logic [DEPTH_W-1:0] DEPTH_6BPC  = 3'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_8BPC  = 3'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_10BPC = 3'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_12BPC = 3'd3;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_DEPTH = 2'd1,
      STATUS_BAD_LANES = 2'd2,
      STATUS_NO_SPEED  = 2'd3
   } lmn_status_type;

   typedef struct packed {
      logic [PCLK_W-1:0]  pixel_clock_khz;
      logic [DEPTH_W-1:0] depth_code;
      logic [LANE_W-1:0]  lane_count;
   } lmn_req_type;

   typedef struct packed {
      logic [MN_W-1:0] data_m;
      logic [MN_W-1:0] data_n;
      logic [MN_W-1:0] link_m;
      logic [MN_W-1:0] link_n;
      lmn_status_type  status;
   } lmn_rsp_type;

   typedef struct packed {
      logic               start;
      logic [DVD_W-1:0]   dividend;
      logic [SPEED_W-1:0] divisor;
   } lmn_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } lmn_div_rsp_type;

   function automatic logic [BPP_W-1:0] bpp_of(input logic [DEPTH_W-1:0] code);
      logic [BPP_W-1:0] bpp;
      case (code)
         DEPTH_6BPC:  bpp = BPP_W'(18);
         DEPTH_8BPC:  bpp = BPP_W'(24);
         DEPTH_10BPC: bpp = BPP_W'(30);
         DEPTH_12BPC: bpp = BPP_W'(36);
         default:     bpp = '0;
      endcase
      return bpp;
   endfunction

endpackage

/* src/lmn_div.sv */
// ----------------------------------------------------------------------------
// lmn_div
// Bit-serial restoring divider: one quotient bit per cycle, the dividend
// shifting out of the top of a register as the quotient shifts into its foot.
// ----------------------------------------------------------------------------
module lmn_div (
   input  logic                     clock,
   input  logic                     reset,
   input  lmn_pkg::lmn_div_req_type div_req,
   output lmn_pkg::lmn_div_rsp_type div_rsp
);
   import lmn_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DVD_W-1:0]   dvq_ff, dvq_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [SPEED_W-1:0] dsr_ff, dsr_in;
   logic [REM_W:0]     trial;
   logic               ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvq_in  = dvq_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, dvq_ff[DVD_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W - 1);
         dvq_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? REM_W'(trial - {1'b0, dsr_ff}) : trial[REM_W-1:0];
         dvq_in = {dvq_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvq_ff <= dvq_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvq_ff;

endmodule

/* src/link_m_n_ratio_calc_top.sv */
// ----------------------------------------------------------------------------
// link_m_n_ratio_calc_top
// Link M/N ratio calculator: data and link M/N pairs from a mode's pixel
// clock, colour depth and lane count, against a programmable link frequency.
// ----------------------------------------------------------------------------
// One item at a time is worked on from acceptance to result:
// each of the two pairs runs through one shared bit-serial restoring divider
// (49 quotient bits), a power-of-two search for N that doubles one bit a
// cycle, and an M reduction that halves M and N one bit a cycle; an item
// with an error status skips these and goes from ST_PREP straight to
// ST_DONE.
// A finished result waits in the output register while the next item is
// taken and worked on. Status 3 flags a zero lane count or zero link
// frequency.
module link_m_n_ratio_calc_top #(
   parameter int MAX_LANES = lmn_pkg::MAX_LANES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lmn_pkg::lmn_req_type         req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lmn_pkg::lmn_rsp_type         rsp_item,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lmn_pkg::FREQ_W-1:0]   csr_data
);
   import lmn_pkg::*;

   localparam int LBW_W = SPEED_W - 3;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_PREP  = 8'b0000_0010,
      ST_SPEED = 8'b0000_0100,
      ST_POW   = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_NORM  = 8'b0010_0000,
      ST_STORE = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [FREQ_W-1:0]  freq_ff, freq_in;
   lmn_req_type        req_ff, req_in;
   logic [BW_W-1:0]    bw_ff, bw_in;
   logic [NUM_W-1:0]   numer_ff, numer_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic [DVD_W-1:0]   m_ff, m_in;
   logic               pair_ff, pair_in;
   lmn_rsp_type        res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lmn_rsp_type        rsp_item_ff, rsp_item_in;

   lmn_div_req_type    div_req;
   lmn_div_rsp_type    div_rsp;
   logic [BPP_W-1:0]   bpp;
   logic [LBW_W-1:0]   lane_bw;
   lmn_status_type     st;
   logic               slot_free;

   lmn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      freq_in      = csr_valid ? csr_data : freq_ff;
      req_in       = req_ff;
      bw_in        = bw_ff;
      numer_in     = numer_ff;
      speed_in     = speed_ff;
      dvd_in       = dvd_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      pair_in      = pair_ff;
      res_in       = res_ff;
      slot_free    = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      div_req.start    = 1'b0;
      div_req.dividend = dvd_ff;
      div_req.divisor  = speed_ff;
      bpp     = bpp_of(req_ff.depth_code);
      lane_bw = LBW_W'(req_ff.lane_count) * LBW_W'(bw_ff);
      st      = STATUS_OK;
      if (bpp == '0) begin
         st = STATUS_BAD_DEPTH;
      end else if (req_ff.lane_count > LANE_W'(MAX_LANES)) begin
         st = STATUS_BAD_LANES;
      end else if (req_ff.lane_count == '0 || freq_ff == '0) begin
         st = STATUS_NO_SPEED;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_item;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            bw_in         = BW_W'(BW_W'(freq_ff) * BW_W'(BW_SCALE));
            numer_in      = NUM_W'(req_ff.pixel_clock_khz) * NUM_W'(bpp);
            pair_in       = 1'b0;
            res_in        = '0;
            res_in.status = st;
            state_in      = (st == STATUS_OK) ? ST_SPEED : ST_DONE;
         end
         ST_SPEED: begin
            if (pair_ff) begin
               speed_in = SPEED_W'(bw_ff);
               dvd_in   = DVD_W'(req_ff.pixel_clock_khz);
            end else begin
               speed_in = {lane_bw, 3'b000};
               dvd_in   = DVD_W'(numer_ff);
            end
            n_in     = N_W'(1);
            state_in = ST_POW;
         end
         ST_POW: begin
            if (SPEED_W'(n_ff) < speed_ff && n_ff < N_CAP) begin
               n_in   = {n_ff[N_W-2:0], 1'b0};
               dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               m_in     = div_rsp.quotient;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (n_ff > MN_MAX || m_ff > DVD_W'(MN_MAX)) begin
               m_in = m_ff >> 1;
               n_in = n_ff >> 1;
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (pair_ff) begin
               res_in.link_m = m_ff[MN_W-1:0];
               res_in.link_n = n_ff;
               state_in      = ST_DONE;
            end else begin
               res_in.data_m = m_ff[MN_W-1:0];
               res_in.data_n = n_ff;
               pair_in       = 1'b1;
               state_in      = ST_SPEED;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         freq_ff      <= FREQ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         freq_ff      <= freq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      bw_ff       <= bw_in;
      numer_ff    <= numer_in;
      speed_ff    <= speed_in;
      dvd_ff      <= dvd_in;
      n_ff        <= n_in;
      m_ff        <= m_in;
      pair_ff     <= pair_in;
      res_ff      <= res_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;

endmodule
